/* design/gfgj_pkg.sv */
package gfgj_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 128;
    localparam int ROW_W = $clog2(MAX_ROWS);
    localparam int COL_W = $clog2(MAX_COLS);
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int RCNT_W = $clog2(MAX_ROWS + 1);
    localparam int CCNT_W = $clog2(MAX_COLS + 1);
    localparam int ROWREG_W = 7;
    localparam int COLREG_W = 8;
    localparam int CFG_W = 8;

    localparam logic [1:0] ACT_LOAD = 2'd0;
    localparam logic [1:0] ACT_ELIM = 2'd1;
    localparam logic [1:0] ACT_READ = 2'd2;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef logic [3:0] gf_t;

    typedef struct packed {
        logic           we;
        logic [ADDR_W-1:0] waddr;
        gf_t            wdata;
        logic           re;
        logic [ADDR_W-1:0] raddr;
    } mem_req_t;

    function automatic gf_t gf_mul(gf_t a, gf_t b);
        gf_t acc;
        gf_t x;
        acc = 4'd0;
        x = a;
        for (int k = 0; k < 4; k++)
        begin
            if (b[k])
                acc = acc ^ x;
            x = {x[2:0], 1'b0} ^ (x[3] ? 4'h3 : 4'h0);
        end
        return acc;
    endfunction

    function automatic gf_t gf_inv(gf_t a);
        case (a)
            4'h1: return 4'h1;
            4'h2: return 4'h9;
            4'h3: return 4'he;
            4'h4: return 4'hd;
            4'h5: return 4'hb;
            4'h6: return 4'h7;
            4'h7: return 4'h6;
            4'h8: return 4'hf;
            4'h9: return 4'h2;
            4'ha: return 4'hc;
            4'hb: return 4'h5;
            4'hc: return 4'ha;
            4'hd: return 4'h4;
            4'he: return 4'h3;
            4'hf: return 4'h8;
            default: return 4'h0;
        endcase
    endfunction

endpackage

/* design/gfgj_ram.sv */
module gfgj_ram #(
    parameter int AW = 13,
    parameter int DW = 4
) (
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [DW-1:0] wdata,
    input  logic          re,
    input  logic [AW-1:0] raddr,
    output logic [DW-1:0] rdata
);

    logic [DW-1:0] mem [2**AW];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        if (re)
            rdata <= mem[raddr];
    end

endmodule

/* design/gfgj_ctrl.sv */
module gfgj_ctrl (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [gfgj_pkg::RCNT_W-1:0]  rows,
    input  logic [gfgj_pkg::CCNT_W-1:0]  cols,
    input  gfgj_pkg::gf_t                rdata,
    output gfgj_pkg::mem_req_t           req,
    output logic                         done,
    output logic [gfgj_pkg::RCNT_W-1:0]  rank
);
    import gfgj_pkg::*;

    // Requests are registered: a read passes req_reg and then the RAM output register before its data is valid.
    typedef enum logic [3:0] {
        S_IDLE, S_SRCH, S_SRCHW, S_SWRD, S_SWA, S_SWB,
        S_PIV, S_PIVW, S_SCRD, S_SCW, S_FRD, S_FW, S_ELRD, S_ELW, S_NEXT
    } state_t;

    state_t state_reg;
    logic [RCNT_W-1:0] pr_reg, ir_reg, fr_reg;
    logic [CCNT_W-1:0] pc_reg, jc_reg;
    gf_t inv_reg, f_reg;
    mem_req_t req_reg;
    logic done_reg;

    // scaled pivot-row values from the pivot column on, kept for elimination
    gf_t prow [MAX_COLS];
    gf_t prow_q;

    function automatic logic [ADDR_W-1:0] adr(logic [RCNT_W-1:0] r, logic [CCNT_W-1:0] c);
        return {r[ROW_W-1:0], c[COL_W-1:0]};
    endfunction

    assign req = req_reg;
    assign done = done_reg;
    assign rank = pr_reg;

    // jc_reg holds still through S_FW / S_ELW, so prow_q matches it in S_ELRD
    always_ff @(posedge clk)
    begin
        if (state_reg == S_SCW)
            prow[jc_reg[COL_W-1:0]] <= gf_mul(rdata,
                (jc_reg == pc_reg) ? gf_inv(rdata) : inv_reg);
        prow_q <= prow[jc_reg[COL_W-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pr_reg <= '0;
            ir_reg <= '0;
            fr_reg <= '0;
            pc_reg <= '0;
            jc_reg <= '0;
            inv_reg <= '0;
            f_reg <= '0;
            req_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            req_reg.we <= 1'b0;
            req_reg.re <= 1'b0;
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        pr_reg <= '0;
                        pc_reg <= '0;
                        state_reg <= S_NEXT;
                    end
                end
                S_NEXT:
                begin
                    if (pr_reg < rows && pc_reg < cols)
                    begin
                        ir_reg <= pr_reg;
                        req_reg.re <= 1'b1;
                        req_reg.raddr <= adr(pr_reg, pc_reg);
                        state_reg <= S_SRCHW;
                    end
                    else
                    begin
                        done_reg <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                end
                S_SRCHW: state_reg <= S_SRCH;
                S_SRCH:
                begin
                    if (rdata != 4'd0)
                    begin
                        fr_reg <= ir_reg;
                        jc_reg <= '0;
                        state_reg <= (ir_reg == pr_reg) ? S_PIV : S_SWRD;
                    end
                    else if (ir_reg + 1'b1 >= rows)
                    begin
                        pc_reg <= pc_reg + 1'b1;
                        state_reg <= S_NEXT;
                    end
                    else
                    begin
                        ir_reg <= ir_reg + 1'b1;
                        req_reg.re <= 1'b1;
                        req_reg.raddr <= adr(ir_reg + 1'b1, pc_reg);
                        state_reg <= S_SRCHW;
                    end
                end
                S_SWRD:
                begin
                    req_reg.re <= 1'b1;
                    req_reg.raddr <= adr(pr_reg, jc_reg);
                    state_reg <= S_SWA;
                end
                S_SWA:
                begin
                    req_reg.re <= 1'b1;
                    req_reg.raddr <= adr(fr_reg, jc_reg);
                    state_reg <= S_SWB;
                end
                S_SWB:
                begin
                    // rdata holds pivot-row entry; next cycle found-row entry
                    req_reg.we <= 1'b1;
                    req_reg.waddr <= adr(fr_reg, jc_reg);
                    req_reg.wdata <= rdata;
                    state_reg <= S_PIVW;
                end
                S_PIVW:
                begin
                    req_reg.we <= 1'b1;
                    req_reg.waddr <= adr(pr_reg, jc_reg);
                    req_reg.wdata <= rdata;
                    if (jc_reg + 1'b1 >= cols)
                    begin
                        jc_reg <= '0;
                        state_reg <= S_PIV;
                    end
                    else
                    begin
                        jc_reg <= jc_reg + 1'b1;
                        state_reg <= S_SWRD;
                    end
                end
                S_PIV:
                begin
                    req_reg.re <= 1'b1;
                    req_reg.raddr <= adr(pr_reg, pc_reg);
                    jc_reg <= pc_reg;
                    state_reg <= S_SCRD;
                end
                S_SCRD:
                begin
                    // wait state; rdata valid in S_SCW for read issued last
                    state_reg <= S_SCW;
                end
                S_SCW:
                begin
                    if (jc_reg == pc_reg)
                        inv_reg <= gf_inv(rdata);
                    req_reg.we <= 1'b1;
                    req_reg.waddr <= adr(pr_reg, jc_reg);
                    req_reg.wdata <= gf_mul(rdata,
                        (jc_reg == pc_reg) ? gf_inv(rdata) : inv_reg);
                    if (jc_reg + 1'b1 >= cols)
                    begin
                        ir_reg <= '0;
                        state_reg <= S_FRD;
                    end
                    else
                    begin
                        jc_reg <= jc_reg + 1'b1;
                        req_reg.re <= 1'b1;
                        req_reg.raddr <= adr(pr_reg, jc_reg + 1'b1);
                        state_reg <= S_SCRD;
                    end
                end
                S_FRD:
                begin
                    if (ir_reg >= rows)
                    begin
                        pr_reg <= pr_reg + 1'b1;
                        pc_reg <= pc_reg + 1'b1;
                        state_reg <= S_NEXT;
                    end
                    else if (ir_reg == pr_reg)
                        ir_reg <= ir_reg + 1'b1;
                    else
                    begin
                        req_reg.re <= 1'b1;
                        req_reg.raddr <= adr(ir_reg, pc_reg);
                        jc_reg <= pc_reg;
                        state_reg <= S_FW;
                    end
                end
                S_FW:
                begin
                    state_reg <= S_ELRD;
                end
                S_ELRD:
                begin
                    if (jc_reg == pc_reg)
                        f_reg <= rdata;
                    if ((jc_reg == pc_reg) ? (rdata == 4'd0) : (f_reg == 4'd0))
                    begin
                        ir_reg <= ir_reg + 1'b1;
                        state_reg <= S_FRD;
                    end
                    else
                    begin
                        req_reg.we <= 1'b1;
                        req_reg.waddr <= adr(ir_reg, jc_reg);
                        req_reg.wdata <= rdata ^ gf_mul((jc_reg == pc_reg) ? rdata : f_reg,
                                                        prow_q);
                        if (jc_reg + 1'b1 >= cols)
                        begin
                            ir_reg <= ir_reg + 1'b1;
                            state_reg <= S_FRD;
                        end
                        else
                        begin
                            jc_reg <= jc_reg + 1'b1;
                            req_reg.re <= 1'b1;
                            req_reg.raddr <= adr(ir_reg, jc_reg + 1'b1);
                            state_reg <= S_ELW;
                        end
                    end
                end
                S_ELW: state_reg <= S_ELRD;
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

/* design/gf16_gauss_jordan_eliminate.sv */
// channel  dir  fields (low bit up)
// s_axis   in   tdata: action[1:0] row_index[7:2] column_index[14:8] entry_value[18:15]
// m_axis   out  tdata: read_value[3:0] rank[10:4] singular[11] bad_index[12]
// cfg      in   cfg_we, cfg_index, cfg_data (0 row_count, 1 column_count)
// Load item: result the cycle after accept; the next item waits until that result is taken.
// Read item: RAM read at accept, then rdpend_reg and the output register; the next item waits for the result.
// Eliminate runs a sequencer over the one-read one-write matrix RAM: it searches the pivot
// column, swaps rows column by column, scales the pivot row and clears the column in other rows.
// rst_n clears rank, singular and control; matrix contents stay undefined.
// Input is held off while elimination runs, a read is in flight or a result waits.
module gf16_gauss_jordan_eliminate (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // action, row_index, column_index, entry_value
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // read_value, rank, singular, bad_index
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import gfgj_pkg::*;

    logic [ROWREG_W-1:0] rowc_reg;
    logic [COLREG_W-1:0] colc_reg;
    logic [RCNT_W-1:0] rows, rank_reg, erank;
    logic [CCNT_W-1:0] cols;
    logic sing_reg, busy_reg, rdpend_reg, bad_reg, ovalid_reg, start, edone;
    logic [RCNT_W-1:0] orank_reg;
    logic [3:0] oread_reg;
    logic osing_reg, obad_reg;
    mem_req_t creq, mreq;
    gf_t rdata;

    logic [1:0] act;
    logic [5:0] ri;
    logic [6:0] ci;
    gf_t ev;
    logic acc, inb;

    assign act = s_axis_tdata[1:0];
    assign ri = s_axis_tdata[7:2];
    assign ci = s_axis_tdata[14:8];
    assign ev = s_axis_tdata[18:15];

    assign rows = (rowc_reg == '0) ? RCNT_W'(1) :
                  ({1'b0, rowc_reg} > (ROWREG_W+1)'(MAX_ROWS)) ? RCNT_W'(MAX_ROWS)
                  : RCNT_W'(rowc_reg);
    assign cols = (colc_reg == '0) ? CCNT_W'(1) :
                  ({1'b0, colc_reg} > (COLREG_W+1)'(MAX_COLS)) ? CCNT_W'(MAX_COLS)
                  : CCNT_W'(colc_reg);

    assign s_axis_tready = !busy_reg && !rdpend_reg && !ovalid_reg;
    assign acc = s_axis_tvalid && s_axis_tready;
    assign inb = ({1'b0, ri} < rows) && ({1'b0, ci} < cols);
    assign start = acc && act == ACT_ELIM;

    always_comb
    begin
        mreq = creq;
        if (!busy_reg)
        begin
            mreq.we = acc && act == ACT_LOAD && inb;
            mreq.waddr = {ri[ROW_W-1:0], ci[COL_W-1:0]};
            mreq.wdata = ev;
            mreq.re = acc && act == ACT_READ && inb;
            mreq.raddr = {ri[ROW_W-1:0], ci[COL_W-1:0]};
        end
    end

    gfgj_ram #(.AW(ADDR_W), .DW(4)) u_ram (
        .clk(clk), .we(mreq.we), .waddr(mreq.waddr), .wdata(mreq.wdata),
        .re(mreq.re), .raddr(mreq.raddr), .rdata(rdata)
    );

    gfgj_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .start(start), .rows(rows), .cols(cols),
        .rdata(rdata), .req(creq), .done(edone), .rank(erank)
    );

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata = {3'd0, obad_reg, osing_reg, orank_reg, oread_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rowc_reg <= ROWREG_W'(64);
            colc_reg <= COLREG_W'(128);
            rank_reg <= '0;
            sing_reg <= 1'b0;
            busy_reg <= 1'b0;
            rdpend_reg <= 1'b0;
            bad_reg <= 1'b0;
            ovalid_reg <= 1'b0;
            orank_reg <= '0;
            oread_reg <= '0;
            osing_reg <= 1'b0;
            obad_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_ROWS)
                    rowc_reg <= cfg_data[ROWREG_W-1:0];
                else
                    colc_reg <= cfg_data;
            end
            rdpend_reg <= 1'b0;
            if (ovalid_reg && m_axis_tready)
                ovalid_reg <= 1'b0;
            if (start)
                busy_reg <= 1'b1;
            if (busy_reg && edone)
            begin
                busy_reg <= 1'b0;
                rank_reg <= erank;
                sing_reg <= erank < rows;
                ovalid_reg <= 1'b1;
                orank_reg <= erank;
                osing_reg <= erank < rows;
                oread_reg <= '0;
                obad_reg <= 1'b0;
            end
            if (rdpend_reg)
            begin
                ovalid_reg <= 1'b1;
                oread_reg <= bad_reg ? 4'd0 : rdata;
                obad_reg <= bad_reg;
                orank_reg <= rank_reg;
                osing_reg <= sing_reg;
            end
            if (acc && act != ACT_ELIM)
            begin
                if (act == ACT_READ)
                begin
                    rdpend_reg <= 1'b1;
                    bad_reg <= !inb;
                end
                else
                begin
                    ovalid_reg <= 1'b1;
                    oread_reg <= '0;
                    obad_reg <= (act == ACT_LOAD) && !inb;
                    orank_reg <= rank_reg;
                    osing_reg <= sing_reg;
                end
            end
        end
    end

endmodule

/* test/tb_gf16_gauss_jordan_eliminate.sv */
`timescale 1ns / 100ps

module tb_gf16_gauss_jordan_eliminate;
    import gfgj_pkg::*;

    localparam logic [1:0] ACT_IDLE = 2'd3;   // unused action code

    typedef struct packed {
        logic       bad_index;
        logic       singular;
        logic [6:0] rank;
        gf_t        read_value;
    } result_t;

    class gj_scoreboard;
        gf_t        cells[MAX_ROWS*MAX_COLS];
        logic [6:0] rows_reg;
        logic [7:0] cols_reg;
        logic [6:0] rank;
        logic       singular;
        result_t    pending[$];
        int         errors;

        function new();
            rows_reg = 7'd64;
            cols_reg = 8'd128;
            rank = 7'd0;
            singular = 1'b0;
            errors = 0;
        endfunction

        function int eff_rows();
            if (rows_reg == 0) return 1;
            if (rows_reg > MAX_ROWS) return MAX_ROWS;
            return rows_reg;
        endfunction

        function int eff_cols();
            if (cols_reg == 0) return 1;
            if (cols_reg > MAX_COLS) return MAX_COLS;
            return cols_reg;
        endfunction

        // carry-less product, then fold bits 6..4 with x^4+x+1
        function gf_t mul(gf_t a, gf_t b);
            logic [6:0] p;
            p = '0;
            for (int i = 0; i < 4; i++)
                if (b[i]) p = p ^ (7'(a) << i);
            for (int i = 6; i >= 4; i--)
                if (p[i]) p = p ^ (7'h13 << (i - 4));
            return p[3:0];
        endfunction

        function gf_t inverse(gf_t a);
            for (int b = 1; b < 16; b++)
                if (mul(a, gf_t'(b)) == 4'h1) return gf_t'(b);
            return 4'h0;
        endfunction

        function void set_register(logic idx, logic [7:0] d);
            if (idx == CFG_ROWS) rows_reg = d[6:0];
            else cols_reg = d;
        endfunction

        function void reduce_matrix();
            int   nr;
            int   nc;
            int   pr;
            int   pc;
            int   hit;
            gf_t  t;
            gf_t  f;
            nr = eff_rows();
            nc = eff_cols();
            pr = 0;
            pc = 0;
            while (pr < nr && pc < nc)
            begin
                hit = -1;
                for (int i = pr; i < nr && hit < 0; i++)
                    if (cells[i*MAX_COLS+pc] != 0) hit = i;
                if (hit < 0)
                begin
                    pc++;
                end
                else
                begin
                    for (int j = 0; j < nc; j++)
                    begin
                        t = cells[pr*MAX_COLS+j];
                        cells[pr*MAX_COLS+j] = cells[hit*MAX_COLS+j];
                        cells[hit*MAX_COLS+j] = t;
                    end
                    f = inverse(cells[pr*MAX_COLS+pc]);
                    for (int j = pc; j < nc; j++)
                        cells[pr*MAX_COLS+j] = mul(cells[pr*MAX_COLS+j], f);
                    for (int i = 0; i < nr; i++)
                    begin
                        if (i != pr)
                        begin
                            f = cells[i*MAX_COLS+pc];
                            for (int j = pc; j < nc; j++)
                                cells[i*MAX_COLS+j] = cells[i*MAX_COLS+j]
                                    ^ mul(f, cells[pr*MAX_COLS+j]);
                        end
                    end
                    pr++;
                    pc++;
                end
            end
            rank = 7'(pr);
            singular = (pr < nr);
        endfunction

        function void note_item(logic [1:0] act, logic [5:0] r, logic [6:0] c, gf_t v);
            result_t e;
            e = '0;
            if (act == ACT_LOAD || act == ACT_READ)
            begin
                if (r >= eff_rows() || c >= eff_cols()) e.bad_index = 1'b1;
                else if (act == ACT_LOAD) cells[r*MAX_COLS+c] = v;
                else e.read_value = cells[r*MAX_COLS+c];
            end
            else if (act == ACT_ELIM)
                reduce_matrix();
            e.rank = rank;
            e.singular = singular;
            pending.push_back(e);
        endfunction

        task report(string what, int got, int want);
            $display("MISMATCH at %0t: %s got %0d want %0d", $realtime, what, got, want);
            errors++;
        endtask

        task check_result(logic [15:0] d);
            result_t g;
            result_t e;
            g = result_t'(d[12:0]);
            if (pending.size() == 0)
            begin
                report("unexpected result, tdata", int'(d), 0);
                return;
            end
            e = pending.pop_front();
            if (g.read_value !== e.read_value) report("read_value", g.read_value, e.read_value);
            if (g.rank !== e.rank) report("rank", g.rank, e.rank);
            if (g.singular !== e.singular) report("singular", g.singular, e.singular);
            if (g.bad_index !== e.bad_index) report("bad_index", g.bad_index, e.bad_index);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        cfg_we;
    logic        cfg_index;
    logic [7:0]  cfg_data;

    gj_scoreboard sb;
    bit gaps_on;
    bit stalls_on;
    int stall_left;
    int item_total;

    gf16_gauss_jordan_eliminate u_top (
        .clk(clk),
        .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    initial
    begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    function int pick_pause(bit enabled);
        int r;
        r = $urandom_range(0, 99);
        if (!enabled || r < 70) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // receiver stalls
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= 1'b1;
            stall_left <= pick_pause(stalls_on);
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);

    // called at a falling edge, returns at a falling edge
    task send_item(logic [1:0] act, logic [5:0] r, logic [6:0] c, gf_t v);
        int gap;
        gap = pick_pause(gaps_on);
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tdata <= {5'd0, v, c, r, act};
        s_axis_tvalid <= 1'b1;
        do @(posedge clk); while (!s_axis_tready);
        sb.note_item(act, r, c, v);
        item_total++;
        @(negedge clk);
    endtask

    task drain();
        s_axis_tvalid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge clk);
    endtask

    task write_register(logic idx, logic [7:0] d);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        sb.set_register(idx, d);
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    function gf_t rand_entry();
        // zero-heavy so skipped columns and rank deficiency show up often
        if ($urandom_range(0, 2) == 0) return 4'h0;
        return gf_t'($urandom_range(0, 15));
    endfunction

    task run_phase(logic [7:0] rows_raw, logic [7:0] cols_raw, int n_ops);
        int nr;
        int nc;
        int sel;
        logic [5:0] r;
        logic [6:0] c;
        drain();
        write_register(CFG_ROWS, rows_raw);
        write_register(CFG_COLS, cols_raw);
        nr = sb.eff_rows();
        nc = sb.eff_cols();
        gaps_on = ($urandom_range(0, 3) != 0);
        stalls_on = ($urandom_range(0, 3) != 0);
        // every active entry written before any read or elimination
        for (int i = 0; i < nr; i++)
            for (int j = 0; j < nc; j++)
                send_item(ACT_LOAD, 6'(i), 7'(j), rand_entry());
        for (int k = 0; k < n_ops; k++)
        begin
            sel = $urandom_range(0, 99);
            r = 6'($urandom_range(0, nr - 1));
            c = 7'($urandom_range(0, nc - 1));
            if (sel < 35)
                send_item(ACT_LOAD, r, c, rand_entry());
            else if (sel < 60)
                send_item(ACT_READ, r, c, gf_t'($urandom_range(0, 15)));
            else if (sel < 75)
                send_item(ACT_ELIM, 6'($urandom), 7'($urandom), gf_t'($urandom));
            else if (sel < 90 && !(nr == MAX_ROWS && nc == MAX_COLS))
            begin
                do
                begin
                    r = 6'($urandom);
                    c = 7'($urandom);
                end
                while (r < nr && c < nc);
                send_item($urandom_range(0, 1) ? ACT_READ : ACT_LOAD, r, c,
                          gf_t'($urandom));
            end
            else
                send_item(ACT_IDLE, 6'($urandom), 7'($urandom), gf_t'($urandom));
        end
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CFG_ROWS;
        cfg_data = '0;
        stall_left = 0;
        gaps_on = 1'b0;
        stalls_on = 1'b0;
        item_total = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: rank reads zero before any elimination, then a 2x3 with a row swap
        send_item(ACT_IDLE, 6'h3f, 7'h7f, 4'hf);
        drain();
        write_register(CFG_ROWS, 8'd2);
        write_register(CFG_COLS, 8'd3);
        send_item(ACT_LOAD, 6'd0, 7'd0, 4'h0);
        send_item(ACT_LOAD, 6'd0, 7'd1, 4'h1);
        send_item(ACT_LOAD, 6'd0, 7'd2, 4'hf);
        send_item(ACT_LOAD, 6'd1, 7'd0, 4'hf);
        send_item(ACT_LOAD, 6'd1, 7'd1, 4'h3);
        send_item(ACT_LOAD, 6'd1, 7'd2, 4'h4);
        send_item(ACT_READ, 6'd0, 7'd2, 4'h0);
        send_item(ACT_READ, 6'd1, 7'd0, 4'h0);
        send_item(ACT_LOAD, 6'h3f, 7'h7f, 4'hf);
        send_item(ACT_READ, 6'd2, 7'd0, 4'h0);
        send_item(ACT_READ, 6'd0, 7'd3, 4'h0);
        send_item(ACT_ELIM, 6'd0, 7'd0, 4'h0);
        send_item(ACT_READ, 6'd0, 7'd0, 4'h0);
        send_item(ACT_READ, 6'd0, 7'd1, 4'h0);
        send_item(ACT_READ, 6'd0, 7'd2, 4'h0);
        send_item(ACT_READ, 6'd1, 7'd2, 4'h0);
        send_item(ACT_LOAD, 6'd0, 7'd0, 4'h0);
        send_item(ACT_LOAD, 6'd1, 7'd0, 4'h0);
        send_item(ACT_ELIM, 6'd0, 7'd0, 4'h0);
        send_item(ACT_READ, 6'd1, 7'd1, 4'h0);

        // size register extremes, including saturation
        run_phase(8'd0, 8'd0, 12);
        run_phase(8'hff, 8'd1, 30);
        run_phase(8'd1, 8'hff, 30);
        run_phase(8'd64, 8'd2, 30);
        run_phase(8'd1, 8'd128, 10);

        while (item_total < 1600)
            run_phase({1'($urandom), 7'($urandom_range(1, 6))},
                      8'($urandom_range(1, 8)), $urandom_range(20, 40));

        drain();
        repeat (200) @(posedge clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* filelist.f */
design/gfgj_pkg.sv
design/gfgj_ram.sv
design/gfgj_ctrl.sv
design/gf16_gauss_jordan_eliminate.sv
test/tb_gf16_gauss_jordan_eliminate.sv
